### src/rfdgl_pkg.sv
package rfdgl_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_COMP_ENABLE    = 3'd0;
    localparam logic [2:0] REG_COMP_RECIP     = 3'd1;
    localparam logic [2:0] REG_SAT_ENABLE     = 3'd2;
    localparam logic [2:0] REG_SAT_POWER      = 3'd3;
    localparam logic [2:0] REG_LIN_GAIN       = 3'd4;
    localparam logic [2:0] REG_LIMITER_ENABLE = 3'd5;
    localparam logic [2:0] REG_REAL_MODE      = 3'd6;

    // Fixed-point constants
    localparam logic [56:0] COMP_CAP     = 57'd15099494;  // 0.9 in Q24
    localparam logic [24:0] ONE_Q24      = 25'd16777216;
    localparam logic [32:0] LIMIT_Q12    = 33'd40960;     // 10.0 in Q11.12
    localparam logic [32:0] LIMIT_SQ     = 33'd1677721600;
    localparam logic [32:0] POS_MAX      = 33'd8388607;
    localparam logic [32:0] NEG_MAX      = 33'd8388608;
    localparam logic [23:0] LIN_GAIN_RST = 24'd65536;

    // Pipeline stage map
    localparam int ST_IN    = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_P     = 2;
    localparam int ST_CP    = 3;
    localparam int ST_CS    = 4;
    localparam int ST_DIV0  = 5;
    localparam int DIV_N    = 49;
    localparam int ST_RT0   = ST_DIV0 + DIV_N;
    localparam int RT_N     = 25;
    localparam int ST_SF    = ST_RT0 + RT_N;
    localparam int ST_G     = ST_SF + 1;
    localparam int ST_Y     = ST_G + 1;
    localparam int ST_L0    = ST_Y + 1;
    localparam int ST_L1    = ST_L0 + 1;
    localparam int ST_L2    = ST_L1 + 1;
    localparam int ST_LR0   = ST_L2 + 1;
    localparam int LR_N     = 32;
    localparam int ST_LDI   = ST_LR0 + LR_N;
    localparam int ST_LD0   = ST_LDI + 1;
    localparam int LD_N     = 16;
    localparam int ST_OUT   = ST_LD0 + LD_N;
    localparam int N_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic        comp_enable;
        logic [31:0] comp_recip;
        logic        sat_enable;
        logic [31:0] sat_power;
        logic [23:0] lin_gain;
        logic        limiter_enable;
        logic        real_mode;
    } cfg_t;

    typedef struct packed {
        logic        nr;
        logic        ni;
        logic [23:0] mr;
        logic [23:0] mi;
        logic [47:0] pr;
        logic [47:0] pi;
        logic [47:0] p;
        logic        hit;
        logic [55:0] chi;
        logic [31:0] clo;
        logic [24:0] s;
        logic [47:0] dr;
        logic [48:0] dq;
        logic [49:0] sv;
        logic [27:0] srem;
        logic [24:0] sroot;
        logic [32:0] g;
        logic [32:0] yr;
        logic [32:0] yi;
        logic        big;
        logic [31:0] sqr;
        logic [31:0] sqi;
        logic [30:0] a;
        logic [30:0] b;
        logic [61:0] a2;
        logic [61:0] b2;
        logic [62:0] lsum;
        logic        lim;
        logic        clip;
        logic [63:0] lv;
        logic [34:0] lrem;
        logic [31:0] m;
        logic [31:0] ar;
        logic [31:0] br;
        logic [15:0] an;
        logic [15:0] bn;
        logic [15:0] aq;
        logic [15:0] bq;
        logic [23:0] ore;
        logic [23:0] oim;
    } item_t;

endpackage

### src/rf_stage_distortion_gain_limiter_top.sv
// Channel  | Ports                               | Payload
// s_ input | s_tvalid s_tready s_tdata[47:0]     | sample_re, sample_im
// m_ result| m_tvalid m_tready m_tdata m_tuser   | out_re, out_im; saturated, limited
// cfg      | cfg_we cfg_index cfg_data           | register write, no read-back
//
// One sample enters per cycle unless a held result on m_tready stalls it.
// The depth is set by the bit-serial P1dB divider (49 stages), the two
// square-root chains (25 and 32 stages) and the limiter divider (16 stages).
// aresetn is synchronous and clears the stage valid bits and the configuration registers.
// A stall on m_tready freezes every stage together; nothing is lost or repeated.
module rf_stage_distortion_gain_limiter_top
    import rfdgl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] sample_re, [47:24] sample_im
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] out_re, [47:24] out_im
    output logic [1:0]  m_tuser,   // [0] saturated, [1] limited
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  ce;
    logic  valid_reg [N_STAGES];
    item_t item_reg  [N_STAGES];
    item_t item_next [N_STAGES];
    item_t in_item;

    // Saturate one magnitude into a signed 24-bit value; bit 24 flags a clip
    function automatic logic [24:0] encode(input logic neg, input logic [32:0] mag);
        logic [32:0] v;
        logic        c;
        v = mag;
        c = 1'b0;
        if (neg) begin
            if (v > NEG_MAX) begin
                v = NEG_MAX;
                c = 1'b1;
            end
            v = 33'd0 - v;
        end else begin
            if (v > POS_MAX) begin
                v = POS_MAX;
                c = 1'b1;
            end
        end
        return {c, v[23:0]};
    endfunction

    // Work of one pipeline stage
    function automatic item_t stage_calc(input int k, input item_t it, input cfg_t c);
        item_t       o;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [55:0] plo;
        logic [56:0] comp;
        logic [48:0] t49;
        logic [27:0] r28;
        logic [26:0] tr27;
        logic [49:0] sf;
        logic [48:0] gp;
        logic [56:0] ypr;
        logic [56:0] ypi;
        logic [34:0] r35;
        logic [33:0] tr34;
        logic [46:0] na;
        logic [46:0] nb;
        logic [32:0] ta;
        logic [32:0] tb;
        logic [32:0] ya;
        logic [32:0] yb;
        logic [24:0] er;
        logic [24:0] ei;
        o = it;
        if (k == ST_IN) begin
            o.nr = it.ore[23];
            o.ni = it.oim[23];
            o.mr = o.nr ? 24'd0 - it.ore : it.ore;
            o.mi = o.ni ? 24'd0 - it.oim : it.oim;
            if (c.real_mode) begin
                o.mi = 24'd0;
                o.ni = 1'b0;
            end
        end else if (k == ST_SQ) begin
            o.pr = 48'(it.mr) * 48'(it.mr);
            o.pi = 48'(it.mi) * 48'(it.mi);
        end else if (k == ST_P) begin
            o.p = it.pr + it.pi;
        end else if (k == ST_CP) begin
            o.chi = 56'(it.p[47:24]) * 56'(c.comp_recip);
            plo   = 56'(it.p[23:0]) * 56'(c.comp_recip);
            o.clo = plo[55:24];
            lhs   = 64'(it.p) * 64'd1000;
            rhs   = (64'(c.sat_power) * 64'd794) << 12;
            o.hit = c.sat_enable && (lhs > rhs);
        end else if (k == ST_CS) begin
            comp = 57'(it.chi) + 57'(it.clo);
            if (comp > COMP_CAP) begin
                comp = COMP_CAP;
            end
            o.s  = c.comp_enable ? ONE_Q24 - 25'(comp[23:0]) : ONE_Q24;
            o.dr = it.hit ? 48'({c.sat_power, 11'd0}) : 48'd0;
            o.dq = 49'd0;
        end else if (k >= ST_DIV0 && k < ST_DIV0 + DIV_N) begin
            // One quotient bit of sat_power * 2^60 / p
            t49 = {it.dr, 1'b0};
            if (t49 >= {1'b0, it.p}) begin
                t49  = t49 - {1'b0, it.p};
                o.dq = {it.dq[47:0], 1'b1};
            end else begin
                o.dq = {it.dq[47:0], 1'b0};
            end
            o.dr = t49[47:0];
        end else if (k >= ST_RT0 && k < ST_RT0 + RT_N) begin
            // One root bit of the saturation factor
            if (k == ST_RT0) begin
                o.sv    = {1'b0, it.dq};
                o.srem  = 28'd0;
                o.sroot = 25'd0;
            end
            r28  = {o.srem[25:0], o.sv[49:48]};
            tr27 = {o.sroot, 2'b01};
            if (r28 >= 28'(tr27)) begin
                o.srem  = r28 - 28'(tr27);
                o.sroot = {o.sroot[23:0], 1'b1};
            end else begin
                o.srem  = r28;
                o.sroot = {o.sroot[23:0], 1'b0};
            end
            o.sv = o.sv << 2;
        end else if (k == ST_SF) begin
            sf = 50'(it.s) * 50'(it.sroot);
            if (it.hit) begin
                o.s = sf[48:24];
            end
        end else if (k == ST_G) begin
            gp  = 49'(it.s) * 49'(c.lin_gain);
            o.g = gp[48:16];
        end else if (k == ST_Y) begin
            ypr  = 57'(it.mr) * 57'(it.g) + 57'(24'h800000);
            ypi  = 57'(it.mi) * 57'(it.g) + 57'(24'h800000);
            o.yr = ypr[56:24];
            o.yi = ypi[56:24];
        end else if (k == ST_L0) begin
            o.big = (it.yr > LIMIT_Q12) || (it.yi > LIMIT_Q12);
            o.sqr = 32'(it.yr[15:0]) * 32'(it.yr[15:0]);
            o.sqi = 32'(it.yi[15:0]) * 32'(it.yi[15:0]);
            // Bring both components below 2^31 for the magnitude
            if (it.yr[32] || it.yi[32]) begin
                o.a = it.yr[32:2];
                o.b = it.yi[32:2];
            end else if (it.yr[31] || it.yi[31]) begin
                o.a = it.yr[31:1];
                o.b = it.yi[31:1];
            end else begin
                o.a = it.yr[30:0];
                o.b = it.yi[30:0];
            end
        end else if (k == ST_L1) begin
            o.lim  = c.limiter_enable && !c.real_mode &&
                     (it.big || (33'(it.sqr) + 33'(it.sqi) > LIMIT_SQ));
            o.clip = c.limiter_enable && c.real_mode && (it.yr > LIMIT_Q12);
            o.a2   = 62'(it.a) * 62'(it.a);
            o.b2   = 62'(it.b) * 62'(it.b);
        end else if (k == ST_L2) begin
            o.lsum = 63'(it.a2) + 63'(it.b2);
        end else if (k >= ST_LR0 && k < ST_LR0 + LR_N) begin
            // One root bit of the limited magnitude
            if (k == ST_LR0) begin
                o.lv   = {1'b0, it.lsum};
                o.lrem = 35'd0;
                o.m    = 32'd0;
            end
            r35  = {o.lrem[32:0], o.lv[63:62]};
            tr34 = {o.m, 2'b01};
            if (r35 >= 35'(tr34)) begin
                o.lrem = r35 - 35'(tr34);
                o.m    = {o.m[30:0], 1'b1};
            end else begin
                o.lrem = r35;
                o.m    = {o.m[30:0], 1'b0};
            end
            o.lv = o.lv << 2;
        end else if (k == ST_LDI) begin
            na   = 47'(it.a) * 47'd40960;
            nb   = 47'(it.b) * 47'd40960;
            o.ar = 32'(na[46:16]);
            o.an = na[15:0];
            o.br = 32'(nb[46:16]);
            o.bn = nb[15:0];
            o.aq = 16'd0;
            o.bq = 16'd0;
        end else if (k >= ST_LD0 && k < ST_LD0 + LD_N) begin
            // One quotient bit of both scaled components over the magnitude
            ta = {it.ar, it.an[15]};
            tb = {it.br, it.bn[15]};
            if (ta >= {1'b0, it.m}) begin
                ta   = ta - {1'b0, it.m};
                o.aq = {it.aq[14:0], 1'b1};
            end else begin
                o.aq = {it.aq[14:0], 1'b0};
            end
            if (tb >= {1'b0, it.m}) begin
                tb   = tb - {1'b0, it.m};
                o.bq = {it.bq[14:0], 1'b1};
            end else begin
                o.bq = {it.bq[14:0], 1'b0};
            end
            o.ar = ta[31:0];
            o.br = tb[31:0];
            o.an = it.an << 1;
            o.bn = it.bn << 1;
        end else if (k == ST_OUT) begin
            ya = it.yr;
            yb = it.yi;
            if (it.clip) begin
                ya = LIMIT_Q12;
            end else if (it.lim && it.m != 32'd0) begin
                ya = 33'(it.aq);
                yb = 33'(it.bq);
            end
            er = encode(it.nr, ya);
            ei = encode(it.ni, yb);
            o.ore  = er[23:0];
            o.oim  = c.real_mode ? 24'd0 : ei[23:0];
            o.clip = it.clip || it.lim || er[24] || (!c.real_mode && ei[24]);
        end
        return o;
    endfunction

    // Pipeline advances unless a finished result is held
    assign ce       = !valid_reg[N_STAGES-1] || m_tready;
    assign s_tready = ce;

    // Load the raw sample into the output fields of a fresh item
    always_comb begin
        in_item     = '0;
        in_item.ore = s_tdata[23:0];
        in_item.oim = s_tdata[47:24];
    end

    // Stage chain
    for (genvar k = 0; k < N_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_comb begin
                item_next[k] = stage_calc(k, in_item, cfg_reg);
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (ce) begin
                    valid_reg[k] <= s_tvalid;
                end
            end
        end else begin : g_rest
            always_comb begin
                item_next[k] = stage_calc(k, item_reg[k-1], cfg_reg);
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (ce) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                item_reg[k] <= item_next[k];
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.comp_enable    <= 1'b0;
            cfg_reg.comp_recip     <= 32'd0;
            cfg_reg.sat_enable     <= 1'b0;
            cfg_reg.sat_power      <= 32'd0;
            cfg_reg.lin_gain       <= LIN_GAIN_RST;
            cfg_reg.limiter_enable <= 1'b0;
            cfg_reg.real_mode      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COMP_ENABLE:    cfg_reg.comp_enable    <= cfg_data[0];
                REG_COMP_RECIP:     cfg_reg.comp_recip     <= cfg_data;
                REG_SAT_ENABLE:     cfg_reg.sat_enable     <= cfg_data[0];
                REG_SAT_POWER:      cfg_reg.sat_power      <= cfg_data;
                REG_LIN_GAIN:       cfg_reg.lin_gain       <= cfg_data[23:0];
                REG_LIMITER_ENABLE: cfg_reg.limiter_enable <= cfg_data[0];
                REG_REAL_MODE:      cfg_reg.real_mode      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Result transfer
    assign m_tvalid = valid_reg[N_STAGES-1];
    assign m_tdata  = {item_reg[N_STAGES-1].oim, item_reg[N_STAGES-1].ore};
    assign m_tuser  = {item_reg[N_STAGES-1].clip, item_reg[N_STAGES-1].hit};

endmodule
